// ===== rtl/monitor_readback_frame_decoder_top_macros.svh =====
// Assertion macros used by the frame decoder top level
`ifndef MONITOR_READBACK_FRAME_DECODER_TOP_MACROS_SVH
`define MONITOR_READBACK_FRAME_DECODER_TOP_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define MRFD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define MRFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mrfd_pkg.sv =====
// Types, constants and the CRC-8 step shared by the frame decoder modules
package mrfd_pkg;

    typedef enum logic [1:0] {
        KIND_CELL = 2'd0,
        KIND_TEMP = 2'd1,
        KIND_CFG  = 2'd2,
        KIND_NONE = 2'd3
    } frame_kind_t;

    // position inside a three-byte code group
    typedef logic [1:0] phase_t;
    localparam phase_t PH_LOW  = 2'd0;
    localparam phase_t PH_MID  = 2'd1;
    localparam phase_t PH_HIGH = 2'd2;

    // configuration register indexes
    localparam logic CFG_POLY = 1'b0;
    localparam logic CFG_SEED = 1'b1;

    localparam logic [7:0] POLY_RESET = 8'h07;
    localparam logic [7:0] SEED_RESET = 8'h41;

    localparam logic [4:0] CELL_LEN = 5'd18;
    localparam logic [4:0] TEMP_LEN = 5'd5;
    localparam logic [4:0] CFG_LEN  = 5'd6;
    localparam logic [4:0] POS_DONE = 5'd31;

    localparam logic [7:0]  NIBBLE_MASK = 8'h0F;
    localparam logic [12:0] CODE_OFFSET = 13'd512;

    typedef struct packed {
        logic [7:0] poly;
        logic [7:0] seed;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  data_byte;
        logic        frame_start;
        frame_kind_t frame_kind;
    } in_item_t;

    typedef struct packed {
        logic               has_result;
        logic signed [12:0] code_value;
        logic [3:0]         code_index;
        logic               is_check;
        logic               pec_ok;
        logic               last;
    } result_t;

    // MSB-first CRC-8, no reflection, no final xor
    function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                               input logic [7:0] b,
                                               input logic [7:0] poly);
        logic [7:0] r;
        r = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (r[7]) begin
                r = {r[6:0], 1'b0} ^ poly;
            end else begin
                r = {r[6:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/monitor_readback_frame_decoder_top.sv =====
// Top level of the battery-monitor readback frame decoder
//
// Slave stream: one received response byte per transaction. s_tdata carries the
// byte, s_tuser[0] marks the first byte of a frame and s_tuser[2:1] gives the
// frame kind (cell, temperature, configuration; code 3 drops the frame).
// Master stream: one result per code, per configuration byte and per PEC byte.
// Code results carry the 12-bit code minus 512 as a 13-bit signed value and its
// index; the PEC result sets is_check, reports pec_ok and raises m_tlast.
// Low bytes of code groups and bytes past the PEC byte give no result.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 polynomial,
// 1 seed) at the clock edge; the seed loads at every frame start.
// Path: an accepted byte waits in the input register and is decoded into the
// result register on m_*. Throughput: one byte per cycle unless m_tready stalls;
// CRC step and unpack fit in the single decode stage between the two registers.
// Stall: with the result register full and m_tready low, one more byte is held
// in the input register, then s_tready drops until the result is taken.
// Reset (aresetn low, synchronous): both stages empty, polynomial 0x07, seed
// 0x41, and the decoder behaves as if a cell frame had just started.
`include "monitor_readback_frame_decoder_top_macros.svh"

module monitor_readback_frame_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata,
    // byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic [2:0]  s_tuser,    // [0] frame_start, [2:1] frame_kind
    // result stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [12:0] code_value, [16:13] code_index, zero pad
    output logic [1:0]  m_tuser,    // [0] is_check, [1] pec_ok
    output logic        m_tlast
);
    import mrfd_pkg::*;

    logic [7:0] pec_poly_reg;
    logic [7:0] pec_seed_reg;
    cfg_t       cfg;
    in_item_t   item;
    result_t    result;
    logic       out_free;
    logic       advance;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pec_poly_reg <= POLY_RESET;
            pec_seed_reg <= SEED_RESET;
        end else if (cfg_we) begin
            if (cfg_index == CFG_POLY) begin
                pec_poly_reg <= cfg_wdata;
            end else begin
                pec_seed_reg <= cfg_wdata;
            end
        end
    end

    assign cfg.poly = pec_poly_reg;
    assign cfg.seed = pec_seed_reg;

    // the held byte moves through decode whenever the result register can take it
    assign advance = item.valid && out_free;

    mrfd_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .advance  (advance),
        .item     (item)
    );

    mrfd_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (item),
        .advance (advance),
        .result  (result)
    );

    mrfd_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .result   (result),
        .advance  (advance),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // check results carry no code and always close the frame
    `MRFD_ASSERT_IMPLY(a_check_fields, m_tvalid && m_tuser[0], m_tdata == 24'd0 && m_tlast, "check result with code data or without last")
    // last and pec_ok only appear on a check result
    `MRFD_ASSERT_IMPLY(a_flags_need_check, m_tvalid && (m_tlast || m_tuser[1]), m_tuser[0], "last or pec_ok outside a check result")
    // code indexes stay within a cell frame
    `MRFD_ASSERT_IMPLY(a_index_range, m_tvalid && !m_tuser[0], m_tdata[16:13] <= 4'd11, "code index out of range")
    // a polynomial write lands in the register
    `MRFD_ASSERT_NEXT(a_poly_write, cfg_we && cfg_index == CFG_POLY, pec_poly_reg == $past(cfg_wdata), "polynomial write lost")

endmodule

// ===== rtl/mrfd_in_stage.sv =====
// Input register stage: holds one accepted byte until the decoder takes it
module mrfd_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic [2:0]         s_tuser,   // [0] frame_start, [2:1] frame_kind
    input  logic               advance,
    output mrfd_pkg::in_item_t item
);
    import mrfd_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic [7:0]  data_reg;
    logic        start_reg;
    frame_kind_t kind_reg;
    logic        load;

    assign s_tready   = !valid_reg || advance;
    assign load       = s_tvalid && s_tready;
    assign valid_next = load ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg  <= s_tdata;
            start_reg <= s_tuser[0];
            kind_reg  <= frame_kind_t'(s_tuser[2:1]);
        end
    end

    always_comb begin
        item.valid       = valid_reg;
        item.data_byte   = data_reg;
        item.frame_start = start_reg;
        item.frame_kind  = kind_reg;
    end

endmodule

// ===== rtl/mrfd_decode.sv =====
// Frame state, running CRC and 12-bit code unpack for one byte per cycle while advance is high
module mrfd_decode (
    input  logic               aclk,
    input  logic               aresetn,
    input  mrfd_pkg::cfg_t     cfg,
    input  mrfd_pkg::in_item_t item,
    input  logic               advance,
    output mrfd_pkg::result_t  result
);
    import mrfd_pkg::*;

    frame_kind_t kind_reg, kind_next, kind_eff;
    logic [4:0]  pos_reg, pos_next, pos_eff;
    logic [7:0]  crc_reg, crc_next, crc_eff;
    logic [3:0]  idx_reg, idx_next, idx_eff;
    logic [7:0]  low_reg, low_next, low_eff;
    logic [3:0]  nib_reg, nib_next, nib_eff;
    phase_t      phase_reg, phase_next, phase_eff;
    logic [4:0]  len;
    logic [7:0]  b;
    logic [11:0] code;

    assign b = item.data_byte;

    always_comb begin
        if (item.frame_start) begin
            kind_eff  = item.frame_kind;
            pos_eff   = '0;
            crc_eff   = cfg.seed;
            idx_eff   = '0;
            low_eff   = '0;
            nib_eff   = '0;
            phase_eff = PH_LOW;
        end else begin
            kind_eff  = kind_reg;
            pos_eff   = pos_reg;
            crc_eff   = crc_reg;
            idx_eff   = idx_reg;
            low_eff   = low_reg;
            nib_eff   = nib_reg;
            phase_eff = phase_reg;
        end
    end

    always_comb begin
        unique case (kind_eff)
            KIND_CELL: len = CELL_LEN;
            KIND_TEMP: len = TEMP_LEN;
            default:   len = CFG_LEN;
        endcase
    end

    always_comb begin
        kind_next  = kind_eff;
        pos_next   = pos_eff;
        crc_next   = crc_eff;
        idx_next   = idx_eff;
        low_next   = low_eff;
        nib_next   = nib_eff;
        phase_next = phase_eff;
        code       = '0;
        result     = '0;

        if (kind_eff != KIND_NONE && pos_eff <= len) begin
            if (pos_eff == len) begin
                // PEC byte closes the frame
                pos_next          = POS_DONE;
                result.has_result = 1'b1;
                result.is_check   = 1'b1;
                result.pec_ok     = (b == crc_eff);
                result.last       = 1'b1;
            end else begin
                crc_next = crc8_update(crc_eff, b, cfg.poly);
                pos_next = pos_eff + 5'd1;
                if (kind_eff == KIND_CFG) begin
                    result.has_result = 1'b1;
                    result.code_value = $signed({5'd0, b});
                    result.code_index = pos_eff[3:0];
                end else begin
                    case (phase_eff)
                        PH_LOW: begin
                            low_next   = b;
                            phase_next = PH_MID;
                        end
                        PH_MID: begin
                            code       = {b[3:0], low_eff};
                            nib_next   = b[7:4];
                            phase_next = PH_HIGH;
                        end
                        default: begin
                            code       = {b, nib_eff};
                            phase_next = PH_LOW;
                        end
                    endcase
                    if (phase_eff != PH_LOW) begin
                        result.has_result = 1'b1;
                        result.code_value = $signed({1'b0, code} - CODE_OFFSET);
                        result.code_index = idx_eff;
                        idx_next          = idx_eff + 4'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg  <= KIND_CELL;
            pos_reg   <= '0;
            crc_reg   <= SEED_RESET;
            idx_reg   <= '0;
            low_reg   <= '0;
            nib_reg   <= '0;
            phase_reg <= PH_LOW;
        end else if (advance) begin
            kind_reg  <= kind_next;
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            idx_reg   <= idx_next;
            low_reg   <= low_next;
            nib_reg   <= nib_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== rtl/mrfd_out_stage.sv =====
// Result register stage driving the master-side stream
module mrfd_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  mrfd_pkg::result_t result,
    input  logic              advance,
    output logic              out_free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // [12:0] code_value, [16:13] code_index, zero pad
    output logic [1:0]        m_tuser,   // [0] is_check, [1] pec_ok
    output logic              m_tlast
);
    import mrfd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        if (advance) begin
            valid_next = result.has_result;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.has_result) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, res_reg.code_index, res_reg.code_value};
    assign m_tuser  = {res_reg.pec_ok, res_reg.is_check};
    assign m_tlast  = res_reg.last;

endmodule

// ===== dv/monitor_readback_frame_decoder_top_tb.sv =====
// Self-checking testbench for the battery-monitor readback frame decoder
`timescale 1ns / 100ps

module monitor_readback_frame_decoder_top_tb;
    import mrfd_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1850;
    localparam int unsigned HOLD_CYCLES  = 150;      // long receiver hold-off
    localparam int unsigned SETTLE       = 4;        // covers the two-stage latency
    localparam int unsigned LIMIT        = 1000000;  // cycle budget for the whole run

    // one decoded result, as carried on the master stream
    typedef struct packed {
        logic signed [12:0] code_value;
        logic [3:0]         code_index;
        logic               is_check;
        logic               pec_ok;
        logic               last;
    } readback_t;

    // per-transaction note: a typed-in expectation overrides the predictor
    typedef struct packed {
        logic      typed;
        logic      has;
        readback_t val;
    } item_tag_t;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_PEC,
        ROW_REG
    } row_op_t;

    typedef struct packed {
        row_op_t     op;
        logic        reg_idx;
        logic [7:0]  reg_val;
        logic [7:0]  b;
        logic        start;
        frame_kind_t kind;
        item_tag_t   tag;
    } dir_row_t;

    localparam item_tag_t NO_TAG = '0;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    monitor_readback_frame_decoder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Decoder model state, advanced on each accepted input transaction
    // ---------------------------------------------------------------
    logic [7:0]  pred_poly = 8'h07;
    logic [7:0]  pred_seed = 8'h41;
    logic [7:0]  crc_acc   = 8'h41;  // out of reset a cell frame is already open
    logic [4:0]  byte_pos  = '0;
    logic [7:0]  low_hold  = '0;
    logic [3:0]  nib_hold  = '0;
    frame_kind_t cur_kind  = KIND_CELL;
    logic [3:0]  code_idx  = '0;

    // sender-side copy, used to build frames that close with a correct PEC
    logic [7:0]  gen_poly  = 8'h07;
    logic [7:0]  gen_seed  = 8'h41;
    logic [7:0]  gen_crc   = 8'h41;

    readback_t   readback_q[$];   // decoded results still owed by the block
    item_tag_t   tag_q[$];        // one per transaction offered on the slave side
    dir_row_t    stim_table[$];
    int unsigned fails      = 0;
    int unsigned live_items = 0;
    bit          tx_gaps_on = 1'b1;
    bit          rx_gaps_on = 1'b1;
    bit          hold_req   = 1'b0;

    // MSB first, no reflection, no final xor
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] r;
        r = crc ^ b;
        repeat (8) r = r[7] ? ((r << 1) ^ poly) : (r << 1);
        return r;
    endfunction

    function automatic int unsigned frame_len(input frame_kind_t k);
        case (k)
            KIND_CELL: return 18;
            KIND_TEMP: return 5;
            default:   return 6;
        endcase
    endfunction

    // returns 1 when the byte produces a result
    function automatic bit decode_byte(input logic [7:0] b, input logic start,
                                       input logic [1:0] kind, output readback_t res);
        int unsigned len;
        logic [4:0]  pos;
        logic [11:0] code;
        res = '0;
        if (start) begin
            cur_kind = frame_kind_t'(kind);
            byte_pos = '0;
            crc_acc  = pred_seed;
            code_idx = '0;
            low_hold = '0;
            nib_hold = '0;
        end
        if (cur_kind == KIND_NONE) return 1'b0;
        len = frame_len(cur_kind);
        pos = byte_pos;
        if (pos > len) return 1'b0;      // past the PEC byte
        if (pos == len) begin
            res.is_check = 1'b1;
            res.pec_ok   = (b == crc_acc);
            res.last     = 1'b1;
            byte_pos     = 5'd31;
            return 1'b1;
        end
        crc_acc  = crc8_next(crc_acc, b, pred_poly);
        byte_pos = pos + 5'd1;
        if (cur_kind == KIND_CFG) begin
            res.code_value = {5'd0, b};
            res.code_index = pos[3:0];
            return 1'b1;
        end
        case (pos % 3)
            0: begin
                low_hold = b;
                return 1'b0;
            end
            1: begin
                code     = {b[3:0], low_hold};
                nib_hold = b[7:4];
            end
            default: begin
                code = {b, nib_hold};
            end
        endcase
        res.code_value = {1'b0, code} - 13'd512;
        res.code_index = code_idx;
        code_idx       = code_idx + 4'd1;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // ---------------------------------------------------------------
    // Monitor: predicts on slave transactions, checks master transactions
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        readback_t pred;
        readback_t want;
        readback_t got;
        item_tag_t tag;
        bit        has;
        if (aresetn) begin
            if (cfg_we) begin
                if (cfg_index == CFG_POLY) pred_poly = cfg_wdata;
                else                       pred_seed = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                tag = tag_q.pop_front();
                has = decode_byte(s_tdata, s_tuser[0], s_tuser[2:1], pred);
                if (tag.typed) begin
                    has  = tag.has;
                    pred = tag.val;
                end
                if (has) readback_q.push_back(pred);
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[12:0], m_tdata[16:13], m_tuser[0], m_tuser[1], m_tlast};
                if (readback_q.size() == 0) begin
                    $error("result with nothing expected: value %0d index %0d check %0b",
                           $signed(got.code_value), got.code_index, got.is_check);
                    fails++;
                end else begin
                    want = readback_q.pop_front();
                    check_field("code_value", want.code_value, got.code_value);
                    check_field("code_index", want.code_index, got.code_index);
                    check_field("is_check", want.is_check, got.is_check);
                    check_field("pec_ok", want.pec_ok, got.pec_ok);
                    check_field("last", want.last, got.last);
                end
            end
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] rand_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] reg_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2) return 8'h00;
        if (r < 4) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // ---------------------------------------------------------------
    // Receiver: random back-pressure, plus one long hold-off on request
    // ---------------------------------------------------------------
    initial begin
        int unsigned g;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                g = rx_gaps_on ? gap_len() : 0;
                if (g != 0) begin
                    m_tready <= 1'b0;
                    repeat (g) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // cycle budget; a hang anywhere ends here
    initial begin
        int unsigned cyc;
        cyc = 0;
        while (cyc < LIMIT) begin
            @(posedge aclk);
            cyc++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------
    // one slave transaction; returns right after the accepting edge
    task automatic send_byte(input logic [7:0] b, input logic start, input logic [1:0] kind,
                             input item_tag_t tag);
        int unsigned g;
        g = tx_gaps_on ? gap_len() : 0;
        if (g != 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        tag_q.push_back(tag);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= {kind, start};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (start) gen_crc = gen_seed;
        gen_crc = crc8_next(gen_crc, b, gen_poly);
    endtask

    // stop sending and wait for the block to empty out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (readback_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // registers only change with the pipeline empty
    task automatic write_reg(input logic idx, input logic [7:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == CFG_POLY) gen_poly = val;
        else                 gen_seed = val;
    endtask

    // a mostly well-formed frame with random content; some are cut short,
    // some close on a bad PEC, some trail ignored bytes
    task automatic send_frame(input bit force_cell);
        frame_kind_t k;
        int unsigned roll;
        int unsigned len;
        int unsigned cut;
        int unsigned extra;
        logic [7:0]  pec_byte;
        roll = $urandom_range(0, 99);
        if (force_cell || roll < 40) k = KIND_CELL;
        else if (roll < 65)          k = KIND_TEMP;
        else if (roll < 93)          k = KIND_CFG;
        else                         k = KIND_NONE;
        len = (k == KIND_NONE) ? $urandom_range(1, 8) : frame_len(k);
        cut = (!force_cell && $urandom_range(0, 9) == 0) ? $urandom_range(1, len) : len + 1;
        for (int unsigned i = 0; i < len && i < cut; i++) begin
            // a polynomial change mid-frame takes effect on the next byte
            if (i != 0 && $urandom_range(0, 149) == 0) write_reg(CFG_POLY, reg_value());
            send_byte(rand_byte(), i == 0, (i == 0) ? k : 2'($urandom_range(0, 3)), NO_TAG);
            if (k != KIND_NONE) live_items++;
        end
        if (cut > len) begin
            pec_byte = ($urandom_range(0, 3) != 0) ? gen_crc : rand_byte();
            send_byte(pec_byte, 1'b0, 2'($urandom_range(0, 3)), NO_TAG);
            if (k != KIND_NONE) live_items++;
            extra = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 3) : 0;
            repeat (extra) send_byte(rand_byte(), 1'b0, 2'($urandom_range(0, 3)), NO_TAG);
        end
    endtask

    // directed table rows
    function automatic dir_row_t byte_row(input logic [7:0] b, input logic start,
                                          input frame_kind_t k);
        dir_row_t r;
        r       = '0;
        r.op    = ROW_BYTE;
        r.b     = b;
        r.start = start;
        r.kind  = k;
        return r;
    endfunction

    function automatic dir_row_t want_row(input logic [7:0] b, input logic start,
                                          input frame_kind_t k, input int v, input int idx);
        dir_row_t r;
        r                    = byte_row(b, start, k);
        r.tag.typed          = 1'b1;
        r.tag.has            = 1'b1;
        r.tag.val.code_value = v[12:0];
        r.tag.val.code_index = idx[3:0];
        return r;
    endfunction

    function automatic dir_row_t none_row(input logic [7:0] b, input logic start,
                                          input frame_kind_t k);
        dir_row_t r;
        r           = byte_row(b, start, k);
        r.tag.typed = 1'b1;
        return r;
    endfunction

    function automatic dir_row_t pec_row();
        dir_row_t r;
        r    = '0;
        r.op = ROW_PEC;
        return r;
    endfunction

    function automatic dir_row_t reg_row(input logic idx, input logic [7:0] v);
        dir_row_t r;
        r         = '0;
        r.op      = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = v;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int unsigned phase;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_POLY;
        cfg_wdata = '0;
        aresetn   = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // out of reset, no frame start: decoded as a cell frame with the reset seed
        stim_table.push_back(none_row(8'h00, 1'b0, KIND_CELL));
        stim_table.push_back(want_row(8'h00, 1'b0, KIND_CELL, -512, 0));   // lowest code
        stim_table.push_back(want_row(8'hFF, 1'b0, KIND_CELL, 3568, 1));
        stim_table.push_back(none_row(8'hFF, 1'b0, KIND_CELL));            // low byte held
        stim_table.push_back(want_row(8'hFF, 1'b0, KIND_CELL, 3583, 2));   // highest code
        stim_table.push_back(want_row(8'hFF, 1'b0, KIND_CELL, 3583, 3));
        // configuration frame: bytes pass straight through, kind ignored mid-frame
        stim_table.push_back(want_row(8'hA5, 1'b1, KIND_CFG, 165, 0));
        stim_table.push_back(want_row(8'h00, 1'b0, KIND_TEMP, 0, 1));
        stim_table.push_back(want_row(8'hFF, 1'b0, KIND_NONE, 255, 2));
        stim_table.push_back(want_row(8'h12, 1'b0, KIND_CELL, 18, 3));
        stim_table.push_back(want_row(8'h34, 1'b0, KIND_CFG, 52, 4));
        stim_table.push_back(want_row(8'h80, 1'b0, KIND_CELL, 128, 5));
        stim_table.push_back(pec_row());
        stim_table.push_back(none_row(8'h55, 1'b0, KIND_CELL));            // after the PEC
        // temperature frame closed by a good PEC
        stim_table.push_back(byte_row(8'h34, 1'b1, KIND_TEMP));
        stim_table.push_back(byte_row(8'h12, 1'b0, KIND_TEMP));
        stim_table.push_back(byte_row(8'hAB, 1'b0, KIND_TEMP));
        stim_table.push_back(byte_row(8'hCD, 1'b0, KIND_TEMP));
        stim_table.push_back(byte_row(8'hEF, 1'b0, KIND_TEMP));
        stim_table.push_back(pec_row());
        // kind 3 drops the whole frame
        stim_table.push_back(none_row(8'h77, 1'b1, KIND_NONE));
        stim_table.push_back(none_row(8'h88, 1'b0, KIND_CFG));
        // register extremes, then a polynomial change in the middle of a frame
        stim_table.push_back(reg_row(CFG_POLY, 8'h00));
        stim_table.push_back(reg_row(CFG_SEED, 8'hFF));
        stim_table.push_back(byte_row(8'h01, 1'b1, KIND_CFG));
        stim_table.push_back(byte_row(8'h02, 1'b0, KIND_CFG));
        stim_table.push_back(byte_row(8'h03, 1'b0, KIND_CFG));
        stim_table.push_back(reg_row(CFG_POLY, 8'hFF));
        stim_table.push_back(byte_row(8'hFE, 1'b0, KIND_CFG));
        stim_table.push_back(byte_row(8'hFD, 1'b0, KIND_CFG));
        stim_table.push_back(byte_row(8'hFC, 1'b0, KIND_CFG));
        stim_table.push_back(byte_row(8'h00, 1'b0, KIND_CFG));            // PEC position

        foreach (stim_table[i]) begin
            case (stim_table[i].op)
                ROW_REG: write_reg(stim_table[i].reg_idx, stim_table[i].reg_val);
                ROW_PEC: send_byte(gen_crc, 1'b0, KIND_CELL, NO_TAG);
                default: send_byte(stim_table[i].b, stim_table[i].start, stim_table[i].kind,
                                   stim_table[i].tag);
            endcase
        end
        drain();

        // random phases, each under its own register setting
        phase = 0;
        while (live_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0: write_reg(CFG_POLY, reg_value());
                1: write_reg(CFG_SEED, reg_value());
                2: begin
                    write_reg(CFG_POLY, reg_value());
                    write_reg(CFG_SEED, reg_value());
                end
                default: ;
            endcase
            tx_gaps_on = ($urandom_range(0, 4) != 0);
            rx_gaps_on = ($urandom_range(0, 4) != 0);
            if (phase == 2) begin
                // receiver holds off while a full cell frame is pushed back to back
                hold_req   = 1'b1;
                tx_gaps_on = 1'b0;
                send_frame(1'b1);
            end
            repeat ($urandom_range(3, 8)) send_frame(1'b0);
            drain();
            phase++;
        end
        drain();

        if (fails == 0 && readback_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mrfd_pkg.sv
rtl/mrfd_in_stage.sv
rtl/mrfd_decode.sv
rtl/mrfd_out_stage.sv
rtl/monitor_readback_frame_decoder_top.sv
dv/monitor_readback_frame_decoder_top_tb.sv
